### rtl/alc_pkg.sv
// ----------------------------------------------------------------------------
// alc_pkg
// shared types, constants and the power table entry function of the
// ambient light lux calculator
// ----------------------------------------------------------------------------
package alc_pkg;

  localparam int unsigned COUNT_W = 16;
  localparam int unsigned LUX_W   = 11;
  localparam int unsigned POW_W   = 20;
  localparam int unsigned COEF_FRAC = 20;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned LIN_W   = 32;

  localparam int unsigned RATIO_FRAC_DEF = 14;
  localparam int unsigned POW_DEPTH_DEF  = 64;
  localparam int unsigned FIFO_DEPTH     = 4;

  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;
  localparam logic [LUX_W-1:0]   LUX_MAX   = '1;

  localparam logic [COEF_W-1:0] K_POW_POS = 16'd31877;
  localparam logic [COEF_W-1:0] K_POW_NEG = 16'd65012;
  localparam logic [COEF_W-1:0] K1_POS    = 16'd23488;
  localparam logic [COEF_W-1:0] K1_NEG    = 16'd32506;
  localparam logic [COEF_W-1:0] K2_POS    = 16'd13422;
  localparam logic [COEF_W-1:0] K2_NEG    = 16'd16043;
  localparam logic [COEF_W-1:0] K3_POS    = 16'd1531;
  localparam logic [COEF_W-1:0] K3_NEG    = 16'd1174;

  typedef enum logic [2:0] {
    BAND_POWER,
    BAND_LOW,
    BAND_MID,
    BAND_HIGH,
    BAND_NONE
  } band_t;

  typedef struct packed {
    logic [COUNT_W-1:0] broad_count;
    logic [COUNT_W-1:0] ir_count;
    logic               invalid;
    logic               over_range;
  } item_t;

  // x^1.4 in q20 for x = idx / (2 * depth)
  function automatic logic [POW_W-1:0] pow_entry(input int unsigned idx,
                                                 input int unsigned depth);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] rem;
    logic [63:0] xq;
    logic [63:0] x2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] m;
    logic [63:0] prod;
    int          b;
    int          n;
    num = 64'(idx) << 30;
    den = 64'(depth) << 1;
    rem = '0;
    xq  = '0;
    for (b = 41; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      xq  = xq << 1;
      if (rem >= den) begin
        rem   = rem - den;
        xq[0] = 1'b1;
      end
    end
    x2 = (xq * xq) >> 30;
    lo = '0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      m   = mid;
      for (n = 0; n < 4; n++) begin
        m = (m * mid) >> 30;
      end
      if (m <= x2) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    prod = (xq * lo) >> 40;
    return prod[POW_W-1:0];
  endfunction

endpackage

### rtl/alc_front.sv
// ----------------------------------------------------------------------------
// alc_front
// input register: takes a count pair and flags invalid or out of range ratios
// ----------------------------------------------------------------------------
module alc_front import alc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COUNT_W-1:0] in_broad_count,
  input  logic [COUNT_W-1:0] in_ir_count,
  output logic               push_valid,
  output item_t              push_item,
  input  logic               fifo_full
);

  logic  front_v_r;
  logic  front_v_nxt;
  item_t item_r;
  item_t item_nxt;
  logic  accept;

  assign in_ready   = !front_v_r || !fifo_full;
  assign accept     = in_valid && in_ready;
  assign push_valid = front_v_r;
  assign push_item  = item_r;

  always_comb begin
    item_nxt.broad_count = in_broad_count;
    item_nxt.ir_count    = in_ir_count;
    item_nxt.invalid     = (in_broad_count == '0) || (in_broad_count == COUNT_SAT) ||
                           (in_ir_count == COUNT_SAT);
    // ratio at or above two is past the top band
    item_nxt.over_range  = {1'b0, in_ir_count} >= {in_broad_count, 1'b0};
    front_v_nxt          = accept || (front_v_r && fifo_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

### rtl/alc_fifo.sv
// ----------------------------------------------------------------------------
// alc_fifo
// short request queue between the front and the back
// ----------------------------------------------------------------------------
module alc_fifo import alc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  input  item_t push_item,
  output logic  fifo_full,
  input  logic  pop,
  output logic  pop_valid,
  output item_t pop_item
);

  localparam int unsigned PW = $clog2(FIFO_DEPTH);

  item_t         mem [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   count_r;
  logic [PW:0]   count_nxt;
  logic          push;
  logic          do_pop;

  assign fifo_full = (count_r == (PW+1)'(FIFO_DEPTH));
  assign pop_valid = (count_r != '0);
  assign push      = push_valid && !fifo_full;
  assign do_pop    = pop && pop_valid;
  assign pop_item  = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

`ifndef ASSERT_OFF
  a_fifo_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !do_pop) |=> count_r == (PW+1)'($past(count_r) + (PW+1)'(1)))
    else $error("queue count did not follow a push");
`endif

endmodule

### rtl/alc_back.sv
// ----------------------------------------------------------------------------
// alc_back
// ratio divider, band select, power table interpolation and lux arithmetic
// ----------------------------------------------------------------------------
module alc_back import alc_pkg::*; #(
  parameter int unsigned RATIO_FRACTION_BITS = RATIO_FRAC_DEF,
  parameter int unsigned POWER_TABLE_DEPTH   = POW_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  input  item_t            pop_item,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [LUX_W-1:0] out_lux_value,
  output logic             out_reading_status
);

  localparam int unsigned F   = RATIO_FRACTION_BITS;
  localparam int unsigned D   = POWER_TABLE_DEPTH;
  localparam int unsigned RW  = F + 1;
  localparam int unsigned DS  = F + 1;
  localparam int unsigned PW  = F + $clog2(2 * D + 1);
  localparam int unsigned KW  = $clog2(D + 1);
  localparam int unsigned IW  = POW_W + F;
  localparam int unsigned M1W = COEF_W + POW_W;
  localparam int unsigned M2W = M1W + COUNT_W;

  localparam logic [RW-1:0] HALF = RW'(1) << (F - 1);
  localparam logic [RW-1:0] B61  = RW'((61 << F) / 100);
  localparam logic [RW-1:0] B80  = RW'((80 << F) / 100);
  localparam logic [RW-1:0] B130 = RW'((130 << F) / 100);
  localparam logic [PW-1:0] TWO_D = PW'(2 * D);
  localparam logic [KW-1:0] K_LAST = KW'(D);

  logic en;

  assign en  = !out_valid || out_ready;
  assign pop = pop_valid && en;

  // power table rom
  logic [POW_W-1:0] ptab [D+1];

  for (genvar gi = 0; gi <= D; gi++) begin : g_tab
    localparam logic [POW_W-1:0] ENTRY = pow_entry(gi, D);
    assign ptab[gi] = ENTRY;
  end

  // restoring divider, one quotient bit per stage
  logic               div_v_r   [DS];
  item_t              div_it_r  [DS];
  logic [COUNT_W-1:0] div_rem_r [DS];
  logic [RW-1:0]      div_q_r   [DS];

  for (genvar g = 0; g < DS; g++) begin : g_div
    logic               v_in;
    item_t              it_in;
    logic [COUNT_W-1:0] rem_in;
    logic [RW-1:0]      q_in;
    logic               nbit;
    logic [COUNT_W:0]   rem_sh;
    logic               ge;
    logic [COUNT_W:0]   rem_sub;
    logic [COUNT_W-1:0] rem_nxt;
    logic [RW-1:0]      q_nxt;

    if (g == 0) begin : g_first
      assign v_in   = pop_valid;
      assign it_in  = pop_item;
      assign rem_in = {1'b0, pop_item.ir_count[COUNT_W-1:1]};
      assign q_in   = '0;
      assign nbit   = pop_item.ir_count[0];
    end else begin : g_next
      assign v_in   = div_v_r[g-1];
      assign it_in  = div_it_r[g-1];
      assign rem_in = div_rem_r[g-1];
      assign q_in   = div_q_r[g-1];
      assign nbit   = 1'b0;
    end

    assign rem_sh  = {rem_in, nbit};
    assign ge      = rem_sh >= {1'b0, it_in.broad_count};
    assign rem_sub = rem_sh - {1'b0, it_in.broad_count};
    assign rem_nxt = ge ? rem_sub[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
    assign q_nxt   = {q_in[RW-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_v_r[g] <= 1'b0;
      end else if (en) begin
        div_v_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_it_r[g]  <= it_in;
        div_rem_r[g] <= rem_nxt;
        div_q_r[g]   <= q_nxt;
      end
    end
  end

  // band select and table index
  logic          a_v_r;
  logic          a_inv_r;
  band_t         a_band_r;
  logic [KW-1:0] a_k_r;
  logic [F-1:0]  a_f_r;
  logic [COUNT_W-1:0] a_broad_r;
  logic [COUNT_W-1:0] a_ir_r;
  band_t         a_band_nxt;
  logic [RW-1:0] ratio;
  logic [F-1:0]  r_lo;
  logic [PW-1:0] p_pos;

  assign ratio = div_q_r[DS-1];

  always_comb begin
    priority if (div_it_r[DS-1].over_range) begin
      a_band_nxt = BAND_NONE;
    end else if (ratio <= HALF) begin
      a_band_nxt = BAND_POWER;
    end else if (ratio <= B61) begin
      a_band_nxt = BAND_LOW;
    end else if (ratio <= B80) begin
      a_band_nxt = BAND_MID;
    end else if (ratio <= B130) begin
      a_band_nxt = BAND_HIGH;
    end else begin
      a_band_nxt = BAND_NONE;
    end
    r_lo  = (a_band_nxt == BAND_POWER) ? ratio[F-1:0] : '0;
    p_pos = PW'(r_lo) * TWO_D;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= div_v_r[DS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_inv_r   <= div_it_r[DS-1].invalid;
      a_band_r  <= a_band_nxt;
      a_k_r     <= p_pos[F +: KW];
      a_f_r     <= p_pos[F-1:0];
      a_broad_r <= div_it_r[DS-1].broad_count;
      a_ir_r    <= div_it_r[DS-1].ir_count;
    end
  end

  // table read and linear products
  logic             b_v_r;
  logic             b_inv_r;
  band_t            b_band_r;
  logic [F-1:0]     b_f_r;
  logic [POW_W-1:0] b_ta_r;
  logic [POW_W-1:0] b_tb_r;
  logic [COUNT_W-1:0] b_broad_r;
  logic [LIN_W-1:0] b_pos_r;
  logic [LIN_W-1:0] b_nlin_r;
  logic [KW-1:0]    k_next;
  logic [COEF_W-1:0] c_pos;
  logic [COEF_W-1:0] c_neg;
  logic [LIN_W-1:0] pos_nxt;
  logic [LIN_W-1:0] nlin_nxt;

  assign k_next = (a_k_r == K_LAST) ? a_k_r : a_k_r + KW'(1);

  always_comb begin
    unique case (a_band_r)
      BAND_POWER: begin
        c_pos = K_POW_POS;
        c_neg = '0;
      end
      BAND_LOW: begin
        c_pos = K1_POS;
        c_neg = K1_NEG;
      end
      BAND_MID: begin
        c_pos = K2_POS;
        c_neg = K2_NEG;
      end
      BAND_HIGH: begin
        c_pos = K3_POS;
        c_neg = K3_NEG;
      end
      BAND_NONE: begin
        c_pos = '0;
        c_neg = '0;
      end
      default: begin
        c_pos = '0;
        c_neg = '0;
      end
    endcase
    pos_nxt  = LIN_W'(c_pos) * LIN_W'(a_broad_r);
    nlin_nxt = LIN_W'(c_neg) * LIN_W'(a_ir_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_inv_r   <= a_inv_r;
      b_band_r  <= a_band_r;
      b_f_r     <= a_f_r;
      b_ta_r    <= ptab[a_k_r];
      b_tb_r    <= ptab[k_next];
      b_broad_r <= a_broad_r;
      b_pos_r   <= pos_nxt;
      b_nlin_r  <= nlin_nxt;
    end
  end

  // interpolation product
  logic             c_v_r;
  logic             c_inv_r;
  band_t            c_band_r;
  logic [POW_W-1:0] c_ta_r;
  logic [POW_W-1:0] c_ip_r;
  logic [COUNT_W-1:0] c_broad_r;
  logic [LIN_W-1:0] c_pos_r;
  logic [LIN_W-1:0] c_nlin_r;
  logic [POW_W-1:0] t_diff;
  logic [IW-1:0]    ip_prod;

  assign t_diff  = (b_tb_r < b_ta_r) ? '0 : b_tb_r - b_ta_r;
  assign ip_prod = IW'(t_diff) * IW'(b_f_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_inv_r   <= b_inv_r;
      c_band_r  <= b_band_r;
      c_ta_r    <= b_ta_r;
      c_ip_r    <= ip_prod[F +: POW_W];
      c_broad_r <= b_broad_r;
      c_pos_r   <= b_pos_r;
      c_nlin_r  <= b_nlin_r;
    end
  end

  // power term times coefficient
  logic             d_v_r;
  logic             d_inv_r;
  band_t            d_band_r;
  logic [M1W-1:0]   d_m1_r;
  logic [COUNT_W-1:0] d_broad_r;
  logic [LIN_W-1:0] d_pos_r;
  logic [LIN_W-1:0] d_nlin_r;
  logic [POW_W-1:0] t_val;
  logic [M1W-1:0]   m1_nxt;

  assign t_val  = c_ta_r + c_ip_r;
  assign m1_nxt = M1W'(K_POW_NEG) * M1W'(t_val);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (en) begin
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_inv_r   <= c_inv_r;
      d_band_r  <= c_band_r;
      d_m1_r    <= m1_nxt;
      d_broad_r <= c_broad_r;
      d_pos_r   <= c_pos_r;
      d_nlin_r  <= c_nlin_r;
    end
  end

  // power band negative term
  logic             e_v_r;
  logic             e_inv_r;
  logic [LIN_W-1:0] e_pos_r;
  logic [LIN_W-1:0] e_neg_r;
  logic [M2W-1:0]   m2_prod;
  logic [LIN_W-1:0] neg_nxt;

  assign m2_prod = M2W'(d_m1_r) * M2W'(d_broad_r);
  assign neg_nxt = (d_band_r == BAND_POWER) ? m2_prod[COEF_FRAC +: LIN_W] : d_nlin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (en) begin
      e_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_inv_r <= d_inv_r;
      e_pos_r <= d_pos_r;
      e_neg_r <= neg_nxt;
    end
  end

  // clamp, truncate and output register
  logic                  out_valid_r;
  logic [LUX_W-1:0]      out_lux_value_r;
  logic                  out_reading_status_r;
  logic [LIN_W-1:0]      l_diff;
  logic [LIN_W-COEF_FRAC-1:0] l_whole;
  logic [LUX_W-1:0]      lux_nxt;

  always_comb begin
    l_diff  = (e_pos_r > e_neg_r) ? e_pos_r - e_neg_r : '0;
    l_whole = l_diff[LIN_W-1:COEF_FRAC];
    if (e_inv_r) begin
      lux_nxt = '0;
    end else if (l_whole > (LIN_W-COEF_FRAC)'(LUX_MAX)) begin
      lux_nxt = LUX_MAX;
    end else begin
      lux_nxt = l_whole[LUX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_lux_value_r      <= lux_nxt;
      out_reading_status_r <= e_inv_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_lux_value      = out_lux_value_r;
  assign out_reading_status = out_reading_status_r;

`ifndef ASSERT_OFF
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (div_v_r[DS-1] && !div_it_r[DS-1].invalid && !div_it_r[DS-1].over_range) |->
      div_rem_r[DS-1] < div_it_r[DS-1].broad_count)
    else $error("divider remainder not below divisor");
  a_tab_index: assert property (@(posedge clk) disable iff (!rst_n)
    (a_v_r && a_band_r == BAND_POWER) |-> a_k_r <= K_LAST)
    else $error("power table index past last entry");
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_reading_status_r) |-> out_lux_value_r == '0)
    else $error("invalid reading with nonzero lux");
`endif

endmodule

### rtl/ambient_light_lux_calc_unit.sv
// throughput: one request per cycle while out_ready holds; one quotient bit per divider stage
// a four entry queue between front and back lets either side stall on its own
// reset: synchronous active low, clears valid flags and queue pointers
// the power table is a constant rom, no fill after reset
// ----------------------------------------------------------------------------
// ambient_light_lux_calc_unit
// two channel photodiode lux calculator with piecewise ratio bands
// ----------------------------------------------------------------------------
module ambient_light_lux_calc_unit import alc_pkg::*; #(
  parameter int unsigned RATIO_FRACTION_BITS = RATIO_FRAC_DEF,
  parameter int unsigned POWER_TABLE_DEPTH   = POW_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COUNT_W-1:0] in_broad_count,
  input  logic [COUNT_W-1:0] in_ir_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LUX_W-1:0]   out_lux_value,
  output logic               out_reading_status
);

  logic  push_valid;
  item_t push_item;
  logic  fifo_full;
  logic  pop;
  logic  pop_valid;
  item_t pop_item;

  alc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_broad_count (in_broad_count),
    .in_ir_count    (in_ir_count),
    .push_valid     (push_valid),
    .push_item      (push_item),
    .fifo_full      (fifo_full)
  );

  alc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .fifo_full  (fifo_full),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item)
  );

  alc_back #(
    .RATIO_FRACTION_BITS (RATIO_FRACTION_BITS),
    .POWER_TABLE_DEPTH   (POWER_TABLE_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .pop_valid          (pop_valid),
    .pop_item           (pop_item),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_lux_value      (out_lux_value),
    .out_reading_status (out_reading_status)
  );

endmodule

### tb/ambient_light_lux_calc_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ambient_light_lux_calc_unit_tb
// drives count pairs into the lux calculator through directed corner cases
// and ratio-shaped random traffic, predicts each lux result in fixed point
// and checks the results in order under random sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module ambient_light_lux_calc_unit_tb import alc_pkg::*;;

  localparam int unsigned RFRAC     = RATIO_FRAC_DEF;
  localparam int unsigned PDEPTH    = POW_DEPTH_DEF;
  localparam int          RAND_REQS = 1630;

  typedef struct {
    logic [LUX_W-1:0] lux;
    logic             status;
  } lux_result_t;

  typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_BURSTY} rx_mode_t;

  class lux_checker;
    longint unsigned pow_q20[PDEPTH+1];
    lux_result_t     lux_expected_q[$];
    int              band_hits[5];
    int              invalid_hits;
    int              accepted;
    int              checked;
    int              errors;

    function new();
      build_pow_table();
    endfunction

    function void build_pow_table();
      longint unsigned two_d, xq, x2, lo, hi, mid, m;
      int i, n;
      two_d = 2 * PDEPTH;
      for (i = 0; i <= PDEPTH; i++) begin
        xq = (longint'(i) << 30) / two_d;
        x2 = (xq * xq) >> 30;
        lo = 0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          m = mid;
          for (n = 0; n < 4; n++) m = (m * mid) >> 30;
          if (m <= x2) lo = mid;
          else hi = mid - 1;
        end
        pow_q20[i] = (xq * lo) >> 40;
      end
    endfunction

    function longint unsigned interp_pow(longint unsigned ratio);
      longint unsigned p, k, f, a, b;
      p = ratio * 2 * PDEPTH;
      k = p >> RFRAC;
      f = p & ((64'd1 << RFRAC) - 1);
      if (k >= PDEPTH) return pow_q20[PDEPTH];
      a = pow_q20[k];
      b = pow_q20[k+1];
      if (b < a) return a;
      return a + (((b - a) * f) >> RFRAC);
    endfunction

    function lux_result_t predict_lux(logic [COUNT_W-1:0] broad, logic [COUNT_W-1:0] ir,
                                      output band_t band);
      lux_result_t     res;
      longint unsigned bc, ic, ratio, pos, neg, lux;
      bc = broad;
      ic = ir;
      band = BAND_NONE;
      if (broad == 0 || broad == COUNT_SAT || ir == COUNT_SAT) begin
        res.lux = '0;
        res.status = 1'b1;
        return res;
      end
      ratio = (ic << RFRAC) / bc;
      pos = 0;
      neg = 0;
      if (ratio <= (64'd1 << (RFRAC - 1))) begin
        band = BAND_POWER;
        pos = K_POW_POS * bc;
        neg = (K_POW_NEG * interp_pow(ratio) * bc) >> COEF_FRAC;
      end else if (ratio <= (64'd61 << RFRAC) / 100) begin
        band = BAND_LOW;
        pos = K1_POS * bc;
        neg = K1_NEG * ic;
      end else if (ratio <= (64'd80 << RFRAC) / 100) begin
        band = BAND_MID;
        pos = K2_POS * bc;
        neg = K2_NEG * ic;
      end else if (ratio <= (64'd130 << RFRAC) / 100) begin
        band = BAND_HIGH;
        pos = K3_POS * bc;
        neg = K3_NEG * ic;
      end
      lux = (pos > neg) ? ((pos - neg) >> COEF_FRAC) : 0;
      if (lux > LUX_MAX) lux = LUX_MAX;
      res.lux = lux[LUX_W-1:0];
      res.status = 1'b0;
      return res;
    endfunction

    function void note_request(logic [COUNT_W-1:0] broad, logic [COUNT_W-1:0] ir);
      band_t       band;
      lux_result_t res;
      res = predict_lux(broad, ir, band);
      if (res.status) invalid_hits++;
      else band_hits[int'(band)]++;
      accepted++;
      lux_expected_q.push_back(res);
    endfunction

    function void check_result(logic [LUX_W-1:0] lux, logic status);
      lux_result_t exp_res;
      if (lux_expected_q.size() == 0) begin
        $error("unexpected result lux=%0d status=%0d", lux, status);
        errors++;
        return;
      end
      exp_res = lux_expected_q.pop_front();
      checked++;
      if (lux !== exp_res.lux) begin
        $error("lux_value expected %0d actual %0d", exp_res.lux, lux);
        errors++;
      end
      if (status !== exp_res.status) begin
        $error("reading_status expected %0d actual %0d", exp_res.status, status);
        errors++;
      end
    endfunction

    function int pending();
      return lux_expected_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [COUNT_W-1:0] in_broad_count = '0;
  logic [COUNT_W-1:0] in_ir_count = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [LUX_W-1:0]   out_lux_value;
  logic               out_reading_status;

  lux_checker lux_board = new();
  int         burst_left = 0;
  rx_mode_t   rx_mode = RX_OPEN;
  int         rx_mode_left = 0;
  int         rx_hold_left = 0;

  ambient_light_lux_calc_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_broad_count    (in_broad_count),
    .in_ir_count       (in_ir_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_lux_value     (out_lux_value),
    .out_reading_status(out_reading_status)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      lux_board.check_result(out_lux_value, out_reading_status);
    end
  end

  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(40, 300);
    end
    rx_mode_left--;
    case (rx_mode)
      RX_OPEN: begin
        out_ready <= 1'b1;
      end
      RX_MOSTLY: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      RX_SPARSE: begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        if (rx_hold_left == 0) begin
          rx_hold_left = $urandom_range(1, 20);
          out_ready <= 1'b1;
        end else begin
          rx_hold_left--;
          out_ready <= 1'b0;
        end
      end
    endcase
  end

  task automatic send_request(input logic [COUNT_W-1:0] broad, input logic [COUNT_W-1:0] ir);
    in_valid <= 1'b1;
    in_broad_count <= broad;
    in_ir_count <= ir;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lux_board.note_request(broad, ir);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (lux_board.pending() != 0) @(posedge clk);
  endtask

  task automatic pick_counts(output logic [COUNT_W-1:0] broad, output logic [COUNT_W-1:0] ir);
    int              kind;
    int              mag;
    longint unsigned ratio, irl;
    kind = $urandom_range(0, 99);
    mag = $urandom_range(1, 16);
    broad = COUNT_W'($urandom & ((32'd1 << mag) - 1));
    if (broad == 0) broad = COUNT_W'(1);
    if (broad == COUNT_SAT) broad = COUNT_SAT - COUNT_W'(1);
    if (kind < 8) begin
      case ($urandom_range(0, 2))
        0: begin
          broad = '0;
          ir = COUNT_W'($urandom);
        end
        1: begin
          broad = COUNT_SAT;
          ir = COUNT_W'($urandom);
        end
        default: begin
          broad = COUNT_W'($urandom);
          ir = COUNT_SAT;
        end
      endcase
    end else if (kind < 28) begin
      broad = COUNT_W'($urandom);
      ir = COUNT_W'($urandom);
    end else begin
      if (kind < 40) begin
        case ($urandom_range(0, 3))
          0: ratio = 64'd1 << (RFRAC - 1);
          1: ratio = (64'd61 << RFRAC) / 100;
          2: ratio = (64'd80 << RFRAC) / 100;
          default: ratio = (64'd130 << RFRAC) / 100;
        endcase
        ratio = ratio + $urandom_range(0, 4) - 2;
        broad = COUNT_W'($urandom_range(4096, 65534));
      end else begin
        ratio = $urandom_range(0, 24000);
      end
      irl = (longint'(broad) * ratio) >> RFRAC;
      if (irl >= COUNT_SAT) irl = COUNT_SAT - 1;
      ir = irl[COUNT_W-1:0];
    end
  endtask

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [COUNT_W-1:0] broad, ir;
    logic [31:0]        corner_pairs[22];
    int                 i;
    corner_pairs = '{
      {16'd0, 16'd0}, {16'd0, 16'd1234}, {16'hFFFF, 16'd100}, {16'd500, 16'hFFFF},
      {16'hFFFF, 16'hFFFF}, {16'd0, 16'hFFFF}, {16'd1, 16'd0}, {16'hFFFE, 16'd0},
      {16'hFFFE, 16'hFFFE}, {16'd16384, 16'd8192}, {16'd16384, 16'd8193},
      {16'd16384, 16'd9994}, {16'd16384, 16'd9995}, {16'd16384, 16'd13107},
      {16'd16384, 16'd13108}, {16'd16384, 16'd21299}, {16'd16384, 16'd21300},
      {16'd1, 16'd1}, {16'd100, 16'hFFFE}, {16'hFFFE, 16'd32767}, {16'd3, 16'd1},
      {16'hAAAA, 16'h5555}
    };
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners, ratio bounds and invalid count pairs
    for (i = 0; i < 22; i++) begin
      send_request(corner_pairs[i][31:16], corner_pairs[i][15:0]);
      if (i == 21) drain_results();
      else pace_sender();
    end

    for (i = 0; i < RAND_REQS; i++) begin
      pick_counts(broad, ir);
      send_request(broad, ir);
      if (i == RAND_REQS / 2) drain_results();
      else pace_sender();
    end
    in_valid <= 1'b0;
    while (lux_board.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d requests, %0d results checked, %0d with invalid counts",
             lux_board.accepted, lux_board.checked, lux_board.invalid_hits);
    $display("bands: power %0d, low %0d, mid %0d, high %0d, above top %0d",
             lux_board.band_hits[0], lux_board.band_hits[1], lux_board.band_hits[2],
             lux_board.band_hits[3], lux_board.band_hits[4]);
    if (lux_board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
